// ===== design/adsr_pkg.sv =====
// Shared constants, phase codes and helpers for the ADSR envelope generator.
package adsr_pkg;

    localparam int FRAC_BITS = 24;
    localparam int LEVEL_W   = FRAC_BITS + 1;
    localparam int COEFF_W   = 25;
    localparam int GOAL_W    = 28;
    localparam int DIFF_W    = GOAL_W + 2;
    localparam int PROD_W    = DIFF_W + COEFF_W + 1;
    localparam int CFG_W     = GOAL_W;
    localparam int CFG_IDX_W = 3;
    localparam int PHASE_W   = 2;

    localparam logic [LEVEL_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [DIFF_W-1:0] ONE_DIFF = DIFF_W'(ONE);
    localparam logic signed [DIFF_W-1:0] REL_TARGET =
        -$signed(DIFF_W'(((64'd1) << FRAC_BITS) / 100));

    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEFF  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEFF   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE_COEFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_GOAL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN_LEVEL = 3'd4;

    localparam logic [COEFF_W-1:0] ATTACK_COEFF_RST  = 25'd16125;
    localparam logic [COEFF_W-1:0] DECAY_COEFF_RST   = 25'd3495;
    localparam logic [COEFF_W-1:0] RELEASE_COEFF_RST = 25'd3495;
    localparam logic [GOAL_W-1:0]  ATTACK_GOAL_RST   = 28'd16944989;
    localparam logic [COEFF_W-1:0] SUSTAIN_LEVEL_RST = 25'd11744051;

    localparam logic [PHASE_W-1:0] PHASE_CODE_IDLE    = 2'd0;
    localparam logic [PHASE_W-1:0] PHASE_CODE_ATTACK  = 2'd1;
    localparam logic [PHASE_W-1:0] PHASE_CODE_DECAY   = 2'd2;
    localparam logic [PHASE_W-1:0] PHASE_CODE_RELEASE = 2'd3;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_ATTACK  = 4'b0010,
        PH_DECAY   = 4'b0100,
        PH_RELEASE = 4'b1000
    } phase_t;

    function automatic logic [LEVEL_W-1:0] sat_one(input logic [COEFF_W-1:0] v);
        logic [LEVEL_W-1:0] r;
        if (v > COEFF_W'(ONE))
            r = ONE;
        else
            r = LEVEL_W'(v);
        return r;
    endfunction

    function automatic logic [PHASE_W-1:0] phase_code(input phase_t p);
        logic [PHASE_W-1:0] c;
        case (p)
            PH_IDLE:    c = PHASE_CODE_IDLE;
            PH_ATTACK:  c = PHASE_CODE_ATTACK;
            PH_DECAY:   c = PHASE_CODE_DECAY;
            PH_RELEASE: c = PHASE_CODE_RELEASE;
            default:    c = PHASE_CODE_IDLE;
        endcase
        return c;
    endfunction

endpackage

// ===== design/adsr_if.sv =====
// Valid/ready channel interfaces for sample ticks and envelope results.
interface adsr_in_if;
    logic valid;
    logic ready;
    logic gate;
    logic retrigger;
    logic hard_restart;

    modport source (output valid, gate, retrigger, hard_restart, input ready);
    modport sink   (input valid, gate, retrigger, hard_restart, output ready);
endinterface

interface adsr_out_if;
    logic                          valid;
    logic                          ready;
    logic [adsr_pkg::LEVEL_W-1:0]  envelope;
    logic [adsr_pkg::PHASE_W-1:0]  phase;

    modport source (output valid, envelope, phase, input ready);
    modport sink   (input valid, envelope, phase, output ready);
endinterface

// ===== design/adsr_envelope_generator.sv =====
// ADSR envelope generator: one-pole exponential segments, one sample per beat.
//
// Channels: in_ch takes one sample tick per beat (gate, retrigger,
// hard_restart); out_ch gives one result per tick (envelope in Q24, phase
// code 0 idle, 1 attack, 2 decay, 3 release).
// A tick is held in an input register, then one multiply-add step on the
// level register loads the result register.
// Throughput is one tick per cycle while out_ch does not stall; the level loop
// (one 26x30 multiply, a shift and an add) closes through the level register alone.
// When out_ch stalls, the result register holds and one further tick waits
// in the input register; in_ch.ready drops only when both are full.
// Configuration: cfg_we writes cfg_data into register cfg_index (attack
// coefficient, decay coefficient, release coefficient, attack goal, sustain
// level); unknown indexes are ignored. Write only while the block is idle.
// Reset: rst_n clears both registers, the phase to idle, the level and the
// previous gate to zero, and loads the default coefficients and targets.
module adsr_envelope_generator (
    input  logic                            clk,
    input  logic                            rst_n,
    adsr_in_if.sink                         in_ch,
    adsr_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [adsr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [adsr_pkg::CFG_W-1:0]      cfg_data
);

    logic [adsr_pkg::COEFF_W-1:0] attack_coeff_reg;
    logic [adsr_pkg::COEFF_W-1:0] decay_coeff_reg;
    logic [adsr_pkg::COEFF_W-1:0] release_coeff_reg;
    logic [adsr_pkg::GOAL_W-1:0]  attack_goal_reg;
    logic [adsr_pkg::COEFF_W-1:0] sustain_level_reg;

    logic in_valid_reg;
    logic gate_reg;
    logic retrigger_reg;
    logic hard_restart_reg;

    adsr_pkg::phase_t              phase_reg, phase_next, phase_pre;
    logic                          last_gate_reg;
    logic [adsr_pkg::LEVEL_W-1:0]  level_reg, level_next, level_pre;

    logic                          out_valid_reg;
    logic [adsr_pkg::LEVEL_W-1:0]  envelope_reg, envelope_next;

    logic advance;
    logic process;

    logic [adsr_pkg::LEVEL_W-1:0]        coeff;
    logic signed [adsr_pkg::DIFF_W-1:0]  target;
    logic signed [adsr_pkg::DIFF_W-1:0]  level_s;
    logic signed [adsr_pkg::DIFF_W-1:0]  diff;
    logic signed [adsr_pkg::LEVEL_W:0]   coeff_s;
    logic signed [adsr_pkg::PROD_W-1:0]  prod;
    logic signed [adsr_pkg::DIFF_W-1:0]  step;
    logic signed [adsr_pkg::DIFF_W-1:0]  sum;
    logic [adsr_pkg::GOAL_W-1:0]         goal;

    assign advance     = !out_valid_reg || out_ch.ready;
    assign process     = in_valid_reg && advance;
    assign in_ch.ready = !in_valid_reg || advance;

    assign out_ch.valid    = out_valid_reg;
    assign out_ch.envelope = envelope_reg;
    assign out_ch.phase    = adsr_pkg::phase_code(phase_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_coeff_reg  <= adsr_pkg::ATTACK_COEFF_RST;
            decay_coeff_reg   <= adsr_pkg::DECAY_COEFF_RST;
            release_coeff_reg <= adsr_pkg::RELEASE_COEFF_RST;
            attack_goal_reg   <= adsr_pkg::ATTACK_GOAL_RST;
            sustain_level_reg <= adsr_pkg::SUSTAIN_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                adsr_pkg::REG_ATTACK_COEFF:  attack_coeff_reg  <= cfg_data[adsr_pkg::COEFF_W-1:0];
                adsr_pkg::REG_DECAY_COEFF:   decay_coeff_reg   <= cfg_data[adsr_pkg::COEFF_W-1:0];
                adsr_pkg::REG_RELEASE_COEFF: release_coeff_reg <= cfg_data[adsr_pkg::COEFF_W-1:0];
                adsr_pkg::REG_ATTACK_GOAL:   attack_goal_reg   <= cfg_data;
                adsr_pkg::REG_SUSTAIN_LEVEL: sustain_level_reg <= cfg_data[adsr_pkg::COEFF_W-1:0];
                default:                     ;
            endcase
        end
    end

    always_comb
    begin
        level_pre = (retrigger_reg && hard_restart_reg) ? '0 : level_reg;
        phase_pre = retrigger_reg ? adsr_pkg::PH_ATTACK : phase_reg;
        if (gate_reg && !last_gate_reg)
            phase_pre = adsr_pkg::PH_ATTACK;
        else if (!gate_reg && last_gate_reg)
            phase_pre = adsr_pkg::PH_RELEASE;

        goal = (attack_goal_reg < adsr_pkg::GOAL_W'(adsr_pkg::ONE)) ?
               adsr_pkg::GOAL_W'(adsr_pkg::ONE) : attack_goal_reg;

        case (phase_pre)
            adsr_pkg::PH_ATTACK:
            begin
                coeff  = adsr_pkg::sat_one(attack_coeff_reg);
                target = $signed(adsr_pkg::DIFF_W'(goal));
            end
            adsr_pkg::PH_DECAY:
            begin
                coeff  = adsr_pkg::sat_one(decay_coeff_reg);
                target = $signed(adsr_pkg::DIFF_W'(adsr_pkg::sat_one(sustain_level_reg)));
            end
            adsr_pkg::PH_RELEASE:
            begin
                coeff  = adsr_pkg::sat_one(release_coeff_reg);
                target = adsr_pkg::REL_TARGET;
            end
            default:
            begin
                coeff  = '0;
                target = '0;
            end
        endcase

        level_s = $signed(adsr_pkg::DIFF_W'(level_pre));
        diff    = target - level_s;
        coeff_s = $signed({1'b0, coeff});
        prod    = adsr_pkg::PROD_W'(coeff_s) * adsr_pkg::PROD_W'(diff);
        step    = prod[adsr_pkg::FRAC_BITS +: adsr_pkg::DIFF_W];
        sum     = level_s + step;

        phase_next    = phase_pre;
        level_next    = level_pre;
        envelope_next = '0;
        case (phase_pre)
            adsr_pkg::PH_ATTACK:
            begin
                if (sum > adsr_pkg::ONE_DIFF)
                begin
                    level_next = adsr_pkg::ONE;
                    phase_next = adsr_pkg::PH_DECAY;
                end
                else
                    level_next = sum[adsr_pkg::LEVEL_W-1:0];
                envelope_next = level_next;
            end
            adsr_pkg::PH_DECAY, adsr_pkg::PH_RELEASE:
            begin
                if (sum < 0)
                begin
                    level_next = '0;
                    phase_next = adsr_pkg::PH_IDLE;
                end
                else
                    level_next = sum[adsr_pkg::LEVEL_W-1:0];
                envelope_next = level_next;
            end
            default:
            begin
                level_next    = level_pre;
                envelope_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            gate_reg         <= 1'b0;
            retrigger_reg    <= 1'b0;
            hard_restart_reg <= 1'b0;
            out_valid_reg    <= 1'b0;
            envelope_reg     <= '0;
            phase_reg        <= adsr_pkg::PH_IDLE;
            last_gate_reg    <= 1'b0;
            level_reg        <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                in_valid_reg     <= 1'b1;
                gate_reg         <= in_ch.gate;
                retrigger_reg    <= in_ch.retrigger;
                hard_restart_reg <= in_ch.hard_restart;
            end
            else if (process)
                in_valid_reg <= 1'b0;

            if (process)
            begin
                out_valid_reg <= 1'b1;
                envelope_reg  <= envelope_next;
                phase_reg     <= phase_next;
                level_reg     <= level_next;
                last_gate_reg <= gate_reg;
            end
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule
